### design/i2cm_pkg.sv
package i2cm_pkg;

    localparam int unsigned HoldWidth = 8;

    // command codes; six and seven mean nothing and act as none
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_INIT  = 3'd1;
    localparam logic [2:0] CMD_START = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_WRITE = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    // configuration register indexes
    localparam logic REG_SHORT_HOLD = 1'b0;
    localparam logic REG_LONG_HOLD  = 1'b1;

    localparam logic [HoldWidth-1:0] SHORT_HOLD_RESET = 8'd1;
    localparam logic [HoldWidth-1:0] LONG_HOLD_RESET  = 8'd10;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [17:0] {
        PH_IDLE       = 18'h00001,
        PH_ST_A       = 18'h00002,
        PH_ST_B       = 18'h00004,
        PH_ST_C       = 18'h00008,
        PH_SP_A       = 18'h00010,
        PH_SP_B       = 18'h00020,
        PH_WR_LOW     = 18'h00040,
        PH_WR_DATA    = 18'h00080,
        PH_WR_HIGH    = 18'h00100,
        PH_WR_ACKLOW  = 18'h00200,
        PH_WR_ACKHIGH = 18'h00400,
        PH_WR_END     = 18'h00800,
        PH_RD_LOW     = 18'h01000,
        PH_RD_HIGH    = 18'h02000,
        PH_RD_ACKLOW  = 18'h04000,
        PH_RD_ACKDATA = 18'h08000,
        PH_RD_ACKHIGH = 18'h10000,
        PH_RD_END     = 18'h20000
    } phase_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       slave_ack;
    } out_t;

    typedef struct packed {
        logic [HoldWidth-1:0] short_hold;
        logic [HoldWidth-1:0] long_hold;
    } cfg_t;

endpackage

### design/i2cm_core.sv
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step_en,
    input  in_t  item,
    input  cfg_t cfg,
    output out_t result
);

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] wait_reg, wait_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ack_seen_reg, ack_seen_next;
    logic       ack_to_send_reg, ack_to_send_next;
    logic [7:0] rx_byte_reg, rx_byte_next;
    logic       done;
    logic [3:0] bit_index_inc;
    logic [7:0] shift_in;

    assign bit_index_inc = bit_index_reg + 4'd1;
    assign shift_in      = {shift_reg[6:0], item.sda_in};

    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        wait_next        = wait_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        ack_seen_next    = ack_seen_reg;
        ack_to_send_next = ack_to_send_reg;
        rx_byte_next     = rx_byte_reg;
        done             = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            case (item.command)
                CMD_INIT:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    done     = 1'b1;
                end
                CMD_START:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_ST_A;
                    wait_next  = cfg.short_hold;
                end
                CMD_STOP:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    phase_next = PH_SP_A;
                    wait_next  = cfg.short_hold;
                end
                CMD_WRITE:
                begin
                    shift_next     = item.write_data;
                    bit_index_next = 4'd0;
                    scl_next       = 1'b0;
                    phase_next     = PH_WR_LOW;
                    wait_next      = cfg.short_hold;
                end
                CMD_READ:
                begin
                    shift_next       = 8'd0;
                    bit_index_next   = 4'd0;
                    ack_to_send_next = item.send_ack;
                    scl_next         = 1'b0;
                    sda_next         = 1'b1;
                    phase_next       = PH_RD_LOW;
                    wait_next        = cfg.long_hold;
                end
                default:
                begin
                end
            endcase
        end
        else if (wait_reg > 8'd1)
        begin
            wait_next = wait_reg - 8'd1;
        end
        else
        begin
            // step ends; a hold of zero lands here as well
            case (phase_reg)
                PH_ST_A:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST_B;
                    wait_next  = cfg.long_hold;
                end
                PH_ST_B:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_ST_C;
                    wait_next  = cfg.short_hold;
                end
                PH_SP_A:
                begin
                    phase_next = PH_SP_B;
                    wait_next  = cfg.long_hold;
                end
                PH_SP_B:
                begin
                    sda_next       = 1'b1;
                    phase_next     = PH_IDLE;
                    wait_next      = 8'd0;
                    bit_index_next = 4'd0;
                    done           = 1'b1;
                end
                PH_WR_LOW:
                begin
                    sda_next   = shift_reg[7];
                    phase_next = PH_WR_DATA;
                    wait_next  = cfg.short_hold;
                end
                PH_WR_DATA:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WR_HIGH;
                    wait_next  = cfg.long_hold;
                end
                PH_WR_HIGH:
                begin
                    shift_next     = {shift_reg[6:0], 1'b0};
                    bit_index_next = bit_index_inc;
                    scl_next       = 1'b0;
                    wait_next      = cfg.short_hold;
                    if (bit_index_inc < BITS_PER_BYTE)
                    begin
                        phase_next = PH_WR_LOW;
                    end
                    else
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_WR_ACKLOW;
                    end
                end
                PH_WR_ACKLOW:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WR_ACKHIGH;
                    wait_next  = cfg.long_hold;
                end
                PH_WR_ACKHIGH:
                begin
                    ack_seen_next = item.sda_in;
                    scl_next      = 1'b0;
                    phase_next    = PH_WR_END;
                    wait_next     = cfg.short_hold;
                end
                PH_RD_LOW:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RD_HIGH;
                    wait_next  = cfg.long_hold;
                end
                PH_RD_HIGH:
                begin
                    shift_next     = shift_in;
                    bit_index_next = bit_index_inc;
                    scl_next       = 1'b0;
                    if (bit_index_inc < BITS_PER_BYTE)
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_RD_LOW;
                        wait_next  = cfg.long_hold;
                    end
                    else
                    begin
                        rx_byte_next = shift_in;
                        phase_next   = PH_RD_ACKLOW;
                        wait_next    = cfg.short_hold;
                    end
                end
                PH_RD_ACKLOW:
                begin
                    sda_next   = ~ack_to_send_reg;
                    phase_next = PH_RD_ACKDATA;
                    wait_next  = cfg.short_hold;
                end
                PH_RD_ACKDATA:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RD_ACKHIGH;
                    wait_next  = cfg.long_hold;
                end
                PH_RD_ACKHIGH:
                begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                    phase_next = PH_RD_END;
                    wait_next  = cfg.short_hold;
                end
                default:
                begin
                    // last steps of start, write and read, and any bad code
                    phase_next     = PH_IDLE;
                    wait_next      = 8'd0;
                    bit_index_next = 4'd0;
                    done           = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            wait_reg        <= 8'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_seen_reg    <= 1'b1;
            ack_to_send_reg <= 1'b0;
            rx_byte_reg     <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            shift_reg       <= shift_next;
            wait_reg        <= wait_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            ack_seen_reg    <= ack_seen_next;
            ack_to_send_reg <= ack_to_send_next;
            rx_byte_reg     <= rx_byte_next;
        end
    end

    always_comb
    begin
        result.scl_out   = scl_next;
        result.sda_out   = sda_next;
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done;
        result.read_data = rx_byte_next;
        result.slave_ack = ack_seen_next;
    end

endmodule

### design/i2c_master_byte_sequencer.sv
// i2c master byte sequencer
// each request on the in channel is one time tick and may carry a command
// (init, start, stop, write byte, read byte); commands given while busy are
// dropped. every request produces exactly one result on the out channel with
// the scl/sda levels to drive, busy/done flags, the last read byte and the
// last slave acknowledge.
// the result of an accepted request goes to the output register, or to
// the skid stage while out_stall holds the output. throughput: one request
// per cycle while in_stall is low; sequencer and hold counter step per tick.
// the result sits in an output register backed by a one-entry skid stage,
// so a request is still taken while a result waits; in_stall rises only
// once the skid entry is occupied, i.e. after out_stall has held a result.
// the user writes hold counts on the cfg port (index 0 short hold, 1 long
// hold) while no command sequence is running; not enforced by the block.
// reset: lines released high, sequencer idle, short hold 1, long hold 10,
// read_data 0, slave_ack 1, no result pending.
module i2c_master_byte_sequencer
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t cfg_reg;
    out_t result;
    out_t out_data_reg;
    out_t skid_data_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic in_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_hold <= SHORT_HOLD_RESET;
            cfg_reg.long_hold  <= LONG_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SHORT_HOLD: cfg_reg.short_hold <= cfg_data;
                REG_LONG_HOLD:  cfg_reg.long_hold  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;

    i2cm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (in_acc),
        .item    (in_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_acc)
            begin
                out_data_reg <= result;
            end
        end
        else if (in_acc)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // skid entry only exists behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output entry");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled while output was free");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.done_res && out_data_reg.busy_res))
        else $error("result flags done and busy together");

endmodule

### tb/i2cm_sequencer_checker.sv
module i2cm_sequencer_checker
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_t        in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_t       out_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output int         errors,
    output int         pending,
    output int         results_seen,
    output int         seqs_done,
    output logic       seq_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the sequencer state
    phase_t               ph;
    logic [3:0]           bit_cnt;
    logic [7:0]           shreg;
    logic [HoldWidth-1:0] hold_cnt;
    logic                 scl_q;
    logic                 sda_q;
    logic                 slv_ack;
    logic                 mst_ack;
    logic [7:0]           rx_byte;
    logic [HoldWidth-1:0] short_h;
    logic [HoldWidth-1:0] long_h;

    out_t expected_q[$];

    assign seq_busy = (ph != PH_IDLE);

    task automatic enter(input phase_t next, input logic [HoldWidth-1:0] hold);
        ph = next;
        hold_cnt = hold;
    endtask

    task automatic back_to_idle(output logic fin);
        ph = PH_IDLE;
        hold_cnt = '0;
        bit_cnt = '0;
        fin = 1'b1;
    endtask

    task automatic predict_tick(input in_t req, output out_t res);
        logic fin;
        fin = 1'b0;
        if (ph == PH_IDLE)
        begin
            case (req.command)
                CMD_INIT:
                begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    fin = 1'b1;
                end
                CMD_START:
                begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                    enter(PH_ST_A, short_h);
                end
                CMD_STOP:
                begin
                    sda_q = 1'b0;
                    scl_q = 1'b1;
                    enter(PH_SP_A, short_h);
                end
                CMD_WRITE:
                begin
                    shreg = req.write_data;
                    bit_cnt = '0;
                    scl_q = 1'b0;
                    enter(PH_WR_LOW, short_h);
                end
                CMD_READ:
                begin
                    shreg = '0;
                    bit_cnt = '0;
                    mst_ack = req.send_ack;
                    scl_q = 1'b0;
                    sda_q = 1'b1;
                    enter(PH_RD_LOW, long_h);
                end
                default: ;
            endcase
        end
        else if (hold_cnt > 8'd1)
        begin
            hold_cnt = hold_cnt - 8'd1;
        end
        else
        begin
            case (ph)
                PH_ST_A:
                begin
                    sda_q = 1'b0;
                    enter(PH_ST_B, long_h);
                end
                PH_ST_B:
                begin
                    scl_q = 1'b0;
                    enter(PH_ST_C, short_h);
                end
                PH_SP_A: enter(PH_SP_B, long_h);
                PH_SP_B:
                begin
                    sda_q = 1'b1;
                    back_to_idle(fin);
                end
                PH_WR_LOW:
                begin
                    sda_q = shreg[7];
                    enter(PH_WR_DATA, short_h);
                end
                PH_WR_DATA:
                begin
                    scl_q = 1'b1;
                    enter(PH_WR_HIGH, long_h);
                end
                PH_WR_HIGH:
                begin
                    shreg = {shreg[6:0], 1'b0};
                    bit_cnt = bit_cnt + 4'd1;
                    scl_q = 1'b0;
                    if (bit_cnt < BITS_PER_BYTE)
                    begin
                        enter(PH_WR_LOW, short_h);
                    end
                    else
                    begin
                        // release sda so the slave can answer
                        sda_q = 1'b1;
                        enter(PH_WR_ACKLOW, short_h);
                    end
                end
                PH_WR_ACKLOW:
                begin
                    scl_q = 1'b1;
                    enter(PH_WR_ACKHIGH, long_h);
                end
                PH_WR_ACKHIGH:
                begin
                    slv_ack = req.sda_in;
                    scl_q = 1'b0;
                    enter(PH_WR_END, short_h);
                end
                PH_RD_LOW:
                begin
                    scl_q = 1'b1;
                    enter(PH_RD_HIGH, long_h);
                end
                PH_RD_HIGH:
                begin
                    shreg = {shreg[6:0], req.sda_in};
                    bit_cnt = bit_cnt + 4'd1;
                    scl_q = 1'b0;
                    if (bit_cnt < BITS_PER_BYTE)
                    begin
                        sda_q = 1'b1;
                        enter(PH_RD_LOW, long_h);
                    end
                    else
                    begin
                        rx_byte = shreg;
                        enter(PH_RD_ACKLOW, short_h);
                    end
                end
                PH_RD_ACKLOW:
                begin
                    sda_q = ~mst_ack;
                    enter(PH_RD_ACKDATA, short_h);
                end
                PH_RD_ACKDATA:
                begin
                    scl_q = 1'b1;
                    enter(PH_RD_ACKHIGH, long_h);
                end
                PH_RD_ACKHIGH:
                begin
                    scl_q = 1'b0;
                    sda_q = 1'b1;
                    enter(PH_RD_END, short_h);
                end
                default: back_to_idle(fin);
            endcase
        end
        res.scl_out = scl_q;
        res.sda_out = sda_q;
        res.busy_res = (ph != PH_IDLE);
        res.done_res = fin;
        res.read_data = rx_byte;
        res.slave_ack = slv_ack;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        out_t res;
        if (!rst_n)
        begin
            ph = PH_IDLE;
            bit_cnt = '0;
            shreg = '0;
            hold_cnt = '0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            slv_ack = 1'b1;
            mst_ack = 1'b0;
            rx_byte = '0;
            short_h = SHORT_HOLD_RESET;
            long_h = LONG_HOLD_RESET;
            expected_q.delete();
            errors = 0;
            pending = 0;
            results_seen = 0;
            seqs_done = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with no request outstanding", $time);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("%0t: scl/sda/busy/done/rdata/ack exp %b %b %b %b %h %b",
                                   $time, want.scl_out, want.sda_out, want.busy_res,
                                   want.done_res, want.read_data, want.slave_ack);
                            $display(" got %b %b %b %b %h %b",
                                     out_data.scl_out, out_data.sda_out,
                                     out_data.busy_res, out_data.done_res,
                                     out_data.read_data, out_data.slave_ack);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_tick(in_data, res);
                if (res.done_res)
                    seqs_done++;
                expected_q.push_back(res);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_SHORT_HOLD)
                    short_h = cfg_data;
                else
                    long_h = cfg_data;
            end
            pending = expected_q.size();
        end
    end

endmodule

### tb/tb_i2c_master_byte_sequencer.sv
module tb_i2c_master_byte_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cm_pkg::*;

    // codes outside the command set, must act as none
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_t        in_data;
    logic       out_valid;
    logic       out_stall;
    out_t       out_data;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    int   errors;
    int   pending;
    int   results_seen;
    int   seqs_done;
    logic seq_busy;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_req;
    int hold_off_served;
    int n_settings;
    int cycle_cnt;

    i2c_master_byte_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2cm_sequencer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .seqs_done    (seqs_done),
        .seq_busy     (seq_busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    // receiver side: random stalls, plus long hold-offs on request
    initial
    begin
        out_stall = 1'b0;
        hold_off_served = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req != hold_off_served)
            begin
                hold_off_served++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    function automatic in_t mk(input logic [2:0] c, input logic [7:0] d,
                               input logic a, input logic s);
        in_t t;
        t.command = c;
        t.write_data = d;
        t.send_ack = a;
        t.sda_in = s;
        return t;
    endfunction

    // mostly full commands from idle, with noise commands while busy
    function automatic in_t pick_tick();
        in_t t;
        int  r;
        t = mk(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
        r = $urandom_range(0, 99);
        if (seq_busy)
            t.command = (r < 8) ? 3'($urandom) : CMD_NONE;
        else if (r < 5)
            t.command = CMD_NONE;
        else if (r < 10)
            t.command = CMD_INIT;
        else if (r < 20)
            t.command = CMD_START;
        else if (r < 30)
            t.command = CMD_STOP;
        else if (r < 62)
            t.command = CMD_WRITE;
        else if (r < 94)
            t.command = CMD_READ;
        else if (r < 97)
            t.command = CMD_UNUSED_LO;
        else
            t.command = CMD_UNUSED_HI;
        return t;
    endfunction

    task automatic wait_slot();
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic offer(input in_t item);
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // keep ticking until the running sequence has ended
    task automatic finish_seq(input logic [2:0] pad_cmd, input logic s);
        forever
        begin
            wait_slot();
            if (!seq_busy)
            begin
                in_valid <= 1'b0;
                break;
            end
            offer(mk(pad_cmd, 8'($urandom), 1'($urandom), s));
        end
    endtask

    task automatic settle();
        finish_seq(CMD_NONE, 1'($urandom));
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic issue(input logic [2:0] c, input logic [7:0] d, input logic a,
                         input logic s, input logic [2:0] pad_cmd);
        wait_slot();
        offer(mk(c, d, a, s));
        finish_seq(pad_cmd, s);
    endtask

    task automatic write_holds(input logic [7:0] s, input logic [7:0] l);
        settle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_SHORT_HOLD;
        cfg_data <= s;
        @(negedge clk);
        cfg_index <= REG_LONG_HOLD;
        cfg_data <= l;
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 249) == 0)
                settle();
            wait_slot();
            offer(pick_tick());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_SHORT_HOLD;
        cfg_data = '0;
        send_idle_pct = 21;
        recv_stall_pct = 85;
        hold_off_req = 0;
        n_settings = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset hold values; stop gets a read command on every busy tick
        issue(CMD_INIT, 8'h00, 1'b0, 1'b1, CMD_NONE);
        issue(CMD_START, 8'h00, 1'b0, 1'b1, CMD_NONE);
        issue(CMD_STOP, 8'h00, 1'b0, 1'b1, CMD_READ);

        write_holds(8'd1, 8'd1);
        issue(CMD_START, 8'h00, 1'b0, 1'b1, CMD_NONE);
        issue(CMD_WRITE, 8'hFF, 1'b0, 1'b0, CMD_NONE);
        issue(CMD_WRITE, 8'h00, 1'b1, 1'b1, CMD_START);
        issue(CMD_WRITE, 8'hA5, 1'b0, 1'b0, CMD_WRITE);
        issue(CMD_READ, 8'h00, 1'b1, 1'b1, CMD_NONE);
        issue(CMD_READ, 8'hFF, 1'b0, 1'b0, CMD_STOP);
        issue(CMD_UNUSED_LO, 8'h5A, 1'b1, 1'b0, CMD_NONE);
        issue(CMD_UNUSED_HI, 8'h3C, 1'b0, 1'b1, CMD_NONE);
        issue(CMD_NONE, 8'hC3, 1'b1, 1'b1, CMD_NONE);
        issue(CMD_READ, 8'h00, 1'b1, 1'b0, CMD_INIT);
        issue(CMD_STOP, 8'h00, 1'b0, 1'b1, CMD_INIT);

        run_random(250);
        write_holds(8'd3, 8'd7);
        run_random(100);

        send_idle_pct = 85;
        recv_stall_pct = 21;
        write_holds(8'd2, 8'd1);
        run_random(250);
        write_holds(8'd1, 8'd4);
        run_random(150);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_holds(8'd1, 8'd3);
        hold_off_req++;
        run_random(250);

        // largest holds, kept to the short sequences
        write_holds(8'd255, 8'd255);
        issue(CMD_INIT, 8'h00, 1'b0, 1'b1, CMD_NONE);
        write_holds(8'd255, 8'd1);
        issue(CMD_STOP, 8'h00, 1'b0, 1'b1, CMD_WRITE);
        write_holds(8'd1, 8'd255);
        issue(CMD_START, 8'h00, 1'b0, 1'b1, CMD_NONE);

        // holds of zero step like holds of one
        write_holds(8'd0, 8'd0);
        issue(CMD_WRITE, 8'h96, 1'b0, 1'b0, CMD_READ);
        issue(CMD_READ, 8'h00, 1'b1, 1'b1, CMD_NONE);

        write_holds(8'd1, 8'd2);
        run_random(100);

        settle();
        repeat (4) @(negedge clk);
        $display("checked %0d ticks over %0d hold settings, %0d sequences finished",
                 results_seen, n_settings, seqs_done);
        $display("covered all commands, busy-time commands, and a %0d-cycle output hold-off",
                 HOLD_OFF_CYCLES);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
design/i2cm_pkg.sv
design/i2cm_core.sv
design/i2c_master_byte_sequencer.sv
tb/i2cm_sequencer_checker.sv
tb/tb_i2c_master_byte_sequencer.sv
